/* rtl/pba_pkg.sv */
`default_nettype none

package pba_pkg;

    localparam int NUM_WORDS      = 128;
    localparam int RESERVED_WORDS = 40;

    localparam int BITS_PER_WORD = 32;
    localparam int BIT_AW        = 5;
    localparam int PAGE_W        = 12;
    localparam int WORD_AW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int RESV_CLAMP    = (RESERVED_WORDS > NUM_WORDS) ? NUM_WORDS : RESERVED_WORDS;
    localparam int NUM_PAGES     = NUM_WORDS * BITS_PER_WORD;

    localparam logic [BITS_PER_WORD-1:0] FULL_WORD = '1;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_FREED = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic              full;
        logic [BIT_AW-1:0] idx;
    } bitfind_t;

    function automatic logic [BITS_PER_WORD-1:0] reset_word(input logic [WORD_AW-1:0] w);
        return (int'(w) < RESV_CLAMP) ? FULL_WORD : '0;
    endfunction

endpackage

`default_nettype wire

/* rtl/pba_ram.sv */
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/pba_bitfind.sv */
`default_nettype none

module pba_bitfind
    import pba_pkg::*;
(
    input  wire logic [BITS_PER_WORD-1:0] word,
    output bitfind_t                      res
);

    always_comb
    begin
        res.full = (word == FULL_WORD);
        res.idx  = BIT_AW'(BITS_PER_WORD - 1);
        for (int i = BITS_PER_WORD - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                res.idx = BIT_AW'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/page_bitmap_allocator_unit.sv */
// channel   | handshake            | ports
// ----------+----------------------+--------------------------
// request   | start & !busy        | req_type, page
// result    | done (one cycle)     | page_out, status
//
// a free clears its bit in S_FREE; an out-of-range free is answered straight from S_IDLE
// an allocate scans from the word of the last allocation, at most NUM_WORDS words;
// the bitmap ram gives one word a cycle and one bit finder inspects it
// reset is immediate: per-word valid bits make unwritten words read as their reset value
// done is high for one cycle per request; the receiver cannot stall it
`default_nettype none

module page_bitmap_allocator_unit
    import pba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              req_type,
    input  wire logic [PAGE_W-1:0] page,
    output logic                   done,
    output logic      [PAGE_W-1:0] page_out,
    output logic      [1:0]        status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } state_t;

    state_t               state_reg, state_next;
    logic [WORD_AW-1:0]   cur_reg, cur_next;
    logic [WORD_AW-1:0]   cnt_reg, cnt_next;
    logic [WORD_AW-1:0]   search_reg, search_next;
    logic [BIT_AW-1:0]    bit_reg, bit_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [NUM_WORDS-1:0] valid_reg, valid_next;
    logic                 done_reg, done_next;
    logic [PAGE_W-1:0]    page_out_reg, page_out_next;
    logic [1:0]           status_reg, status_next;

    logic [WORD_AW-1:0]       raddr;
    logic [BITS_PER_WORD-1:0] rdata;
    logic [BITS_PER_WORD-1:0] eff_word;
    logic                     ram_we;
    logic [BITS_PER_WORD-1:0] ram_wdata;
    logic [WORD_AW-1:0]       cur_inc;
    logic [WORD_AW-1:0]       page_word;
    bitfind_t                 find;

    pba_ram #(
        .WIDTH (BITS_PER_WORD),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pba_bitfind u_find (
        .word (eff_word),
        .res  (find)
    );

    assign eff_word  = valid_reg[cur_reg] ? rdata : reset_word(cur_reg);
    assign cur_inc   = (int'(cur_reg) == NUM_WORDS - 1) ? '0 : cur_reg + WORD_AW'(1);
    assign page_word = WORD_AW'(page >> BIT_AW);

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        search_next   = search_reg;
        bit_next      = bit_reg;
        page_next     = page_reg;
        valid_next    = valid_reg;
        done_next     = 1'b0;
        page_out_next = page_out_reg;
        status_next   = status_reg;
        raddr         = cur_inc;
        ram_we        = 1'b0;
        ram_wdata     = eff_word | (BITS_PER_WORD'(1) << find.idx);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    page_next = page;
                    bit_next  = page[BIT_AW-1:0];
                    cnt_next  = '0;
                    if (!req_type)
                    begin
                        raddr      = search_reg;
                        cur_next   = search_reg;
                        state_next = S_SCAN;
                    end
                    else if (int'(page) >= NUM_PAGES)
                    begin
                        done_next     = 1'b1;
                        page_out_next = page;
                        status_next   = ST_RANGE;
                    end
                    else
                    begin
                        raddr      = page_word;
                        cur_next   = page_word;
                        state_next = S_FREE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!find.full)
                begin
                    ram_we              = 1'b1;
                    valid_next[cur_reg] = 1'b1;
                    search_next         = cur_reg;
                    done_next           = 1'b1;
                    page_out_next       = PAGE_W'({cur_reg, find.idx});
                    status_next         = ST_ALLOC;
                    state_next          = S_IDLE;
                end
                else if (int'(cnt_reg) == NUM_WORDS - 1)
                begin
                    done_next     = 1'b1;
                    page_out_next = '0;
                    status_next   = ST_NONE;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + WORD_AW'(1);
                    cur_next = cur_inc;
                end
            end
            S_FREE:
            begin
                ram_we              = 1'b1;
                ram_wdata           = eff_word & ~(BITS_PER_WORD'(1) << bit_reg);
                valid_next[cur_reg] = 1'b1;
                done_next           = 1'b1;
                page_out_next       = page_reg;
                status_next         = ST_FREED;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            search_reg   <= '0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            cur_reg      <= '0;
            cnt_reg      <= '0;
            bit_reg      <= '0;
            page_reg     <= '0;
            page_out_reg <= '0;
            status_reg   <= ST_ALLOC;
        end
        else
        begin
            state_reg    <= state_next;
            search_reg   <= search_next;
            valid_reg    <= valid_next;
            done_reg     <= done_next;
            cur_reg      <= cur_next;
            cnt_reg      <= cnt_next;
            bit_reg      <= bit_next;
            page_reg     <= page_next;
            page_out_reg <= page_out_next;
            status_reg   <= status_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign page_out = page_out_reg;
    assign status   = status_reg;

    // a result word only follows an accepted request or work in progress
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without request");

    // work only begins on an accepted request
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without start");

    // the bitmap is written only on the last cycle of a request
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (done && !busy))
        else $error("bitmap write without result");

    // no free result is ever reported for an out-of-range page
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FREED) |-> (int'(page_out) < NUM_PAGES))
        else $error("free of out-of-range page");

endmodule

`default_nettype wire
